// File: hw/rtl/ptre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptre_pkg: shared types and codes of the pointer tablet report engine
// Holds the item structures carried by the channels, the operation, status
// and register codes, and the fixed report constants.
// ----------------------------------------------------------------------------
package ptre_pkg;

  // Operation codes of an input item.
  localparam logic [2:0] FUNC_MOTION     = 3'd0;
  localparam logic [2:0] FUNC_ABSOLUTE   = 3'd1;
  localparam logic [2:0] FUNC_IN_TOKEN   = 3'd2;
  localparam logic [2:0] FUNC_OUT_TOKEN  = 3'd3;
  localparam logic [2:0] FUNC_GET_REPORT = 3'd4;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_REPORT = 2'd0;
  localparam logic [1:0] STATUS_NAK    = 2'd1;
  localparam logic [1:0] STATUS_STALL  = 2'd2;

  // Report modes.
  localparam logic [7:0] MODE_MOUSE  = 8'd1;
  localparam logic [7:0] MODE_TABLET = 8'd2;

  // Register indexes on the configuration port.
  localparam logic REG_REPORT_MODE = 1'b0;
  localparam logic REG_IDLE_RATE   = 1'b1;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] REPORT_MODE_RESET = 32'd1;

  // The only endpoint that is served by interrupt polls.
  localparam logic [3:0] REPORT_ENDPOINT = 4'd1;

  // Report lengths and room thresholds.
  localparam logic [2:0] MOUSE_LEN_SHORT = 3'd3;
  localparam logic [2:0] MOUSE_LEN_FULL  = 3'd4;
  localparam logic [2:0] TABLET_LEN      = 3'd7;
  localparam logic [6:0] MOUSE_ROOM_MIN  = 7'd4;
  localparam logic [6:0] TABLET_ROOM_MIN = 7'd7;

  // Tablet pressure byte when no contact button is down.
  localparam logic [7:0] PRESSURE_LIFTED = 8'd129;

  // Position scale of the host and width of a scaled coordinate.
  localparam int unsigned POS_W      = 15;
  localparam int unsigned SCALED_W   = 13;
  localparam int unsigned HOST_SHIFT = 15;   // host full scale is 2**15 - 1

  typedef struct packed {
    logic        [2:0]  func;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_wheel;
    logic        [14:0] position_x;
    logic        [14:0] position_y;
    logic        [2:0]  button_bits;
    logic        [3:0]  endpoint;
    logic        [6:0]  room;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] report_length;
    logic [7:0] report_byte0;
    logic [7:0] report_byte1;
    logic [7:0] report_byte2;
    logic [7:0] report_byte3;
    logic [7:0] report_byte4;
    logic [7:0] report_byte5;
    logic [7:0] report_byte6;
  } out_item_t;

endpackage

// File: hw/rtl/ptre_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptre_if: valid/ready channels of the pointer tablet report engine
// One interface for the event and token channel, one for the result channel.
// ----------------------------------------------------------------------------
interface ptre_in_if;
  logic               valid;
  logic               ready;
  ptre_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptre_out_if;
  logic                valid;
  logic                ready;
  ptre_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ptre_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptre_scale: absolute position scaler
// Computes floor(pos * MAX_VAL / 32767) with a constant multiply and a
// reciprocal estimate followed by one compare and correct step.
// ----------------------------------------------------------------------------
module ptre_scale #(
  parameter int unsigned MAX_VAL = 5040
) (
  input  logic [ptre_pkg::POS_W-1:0]    pos,
  output logic [ptre_pkg::SCALED_W-1:0] scaled
);

  localparam int unsigned ProdW = ptre_pkg::POS_W + ptre_pkg::SCALED_W;
  localparam int unsigned EstW  = ProdW + 1;
  localparam int unsigned QW    = EstW - ptre_pkg::HOST_SHIFT;
  localparam int unsigned RemW  = EstW + 1;
  localparam logic [RemW-1:0] Divisor = RemW'((1 << ptre_pkg::HOST_SHIFT) - 1);

  logic [ProdW-1:0] prod;
  logic [EstW-1:0]  est;
  logic [QW-1:0]    q_est;
  logic [RemW-1:0]  rem;
  logic [QW-1:0]    q_fix;

  // 1 / (2**15 - 1) is close to (1 + 2**-15) / 2**15; the estimate is
  // never above the true quotient and at most one below it.
  assign prod  = ProdW'(pos) * ProdW'(MAX_VAL);
  assign est   = EstW'(prod) + EstW'(prod >> ptre_pkg::HOST_SHIFT);
  assign q_est = est[EstW-1:ptre_pkg::HOST_SHIFT];
  assign rem   = RemW'(prod) + RemW'(q_est) - (RemW'(q_est) << ptre_pkg::HOST_SHIFT);
  assign q_fix = (rem >= Divisor) ? q_est + QW'(1) : q_est;
  assign scaled = q_fix[ptre_pkg::SCALED_W-1:0];

endmodule

// File: hw/rtl/pointer_tablet_report_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_tablet_report_engine: pointer-device report engine
// Accepts motion events, bus tokens and get-report requests and answers each
// token or request with one mouse, tablet or empty report transaction, a NAK or a stall.
// ----------------------------------------------------------------------------
// The engine takes one input transaction every clock cycle. Motion and
// absolute-position events only update the internal state and give no
// result; IN tokens, OUT tokens, get-report requests and unknown operations
// each give exactly one result transaction, which appears in the output
// register in the cycle after the input is accepted. All work for an item is
// done between the input handshake and that output register, so the only
// thing that slows the engine is the result side: while a result waits in
// the output register and out_ch.ready is low, in_ch.ready is low too. The
// two configuration registers (report_mode at byte address 0, idle_rate at
// byte address 4) are written over the APB-style port and should only be
// changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module pointer_tablet_report_engine #(
  parameter int unsigned ACCUM_WIDTH  = 16,
  parameter int unsigned TABLET_MAX_X = 5040,
  parameter int unsigned TABLET_MAX_Y = 3780
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ptre_in_if.sink                             in_ch,
  ptre_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptre_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ptre_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ptre_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned AccW  = ACCUM_WIDTH;
  // Sum width wide enough for an accumulator plus a 16-bit delta.
  localparam int unsigned SumW  = ((AccW > 16) ? AccW : 16) + 1;
  localparam logic signed [SumW-1:0] SatHi = {{(SumW-AccW+1){1'b0}}, {(AccW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatLo = {{(SumW-AccW+1){1'b1}}, {(AccW-1){1'b0}}};
  localparam logic signed [AccW-1:0] ByteMax = {{(AccW-7){1'b0}}, 7'h7f};
  localparam logic signed [AccW-1:0] ByteMin = {{(AccW-7){1'b1}}, 7'h00};

  // Configuration registers.
  logic [7:0] report_mode_r;
  logic [7:0] idle_rate_r;

  // Engine state.
  logic signed [AccW-1:0]            accum_x_r,     accum_x_nxt;
  logic signed [AccW-1:0]            accum_y_r,     accum_y_nxt;
  logic signed [AccW-1:0]            accum_wheel_r, accum_wheel_nxt;
  logic [ptre_pkg::SCALED_W-1:0]     scaled_x_r,    scaled_x_nxt;
  logic [ptre_pkg::SCALED_W-2:0]     scaled_y_r,    scaled_y_nxt;
  logic [2:0]                        held_buttons_r, held_buttons_nxt;
  logic                              fresh_data_r,  fresh_data_nxt;

  // Output register.
  logic                              out_valid_r;
  ptre_pkg::out_item_t               out_data_r,    out_data_nxt;
  logic                              has_result;

  logic                              in_accept;
  logic                              cfg_write;

  logic [ptre_pkg::SCALED_W-1:0]     scale_x;
  logic [ptre_pkg::SCALED_W-1:0]     scale_y;

  logic signed [AccW-1:0]            clamp_x, clamp_y, clamp_wheel;

  function automatic logic signed [AccW-1:0] sat_add(
    input logic signed [AccW-1:0] acc,
    input logic signed [15:0]     delta
  );
    logic signed [SumW-1:0] sum;
    sum = SumW'(acc) + SumW'(delta);
    if (sum > SatHi) begin
      sum = SatHi;
    end else if (sum < SatLo) begin
      sum = SatLo;
    end
    return sum[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] clamp_byte(
    input logic signed [AccW-1:0] v
  );
    logic signed [AccW-1:0] c;
    c = v;
    if (v < ByteMin) begin
      c = ByteMin;
    end else if (v > ByteMax) begin
      c = ByteMax;
    end
    return c;
  endfunction

  // Handshakes. The output register frees up in the same cycle it drains.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Configuration port: writes complete in the access phase, never wait.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      ptre_pkg::REG_REPORT_MODE: prdata = ptre_pkg::CFG_DATA_W'(report_mode_r);
      ptre_pkg::REG_IDLE_RATE:   prdata = ptre_pkg::CFG_DATA_W'(idle_rate_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_mode_r <= ptre_pkg::REPORT_MODE_RESET[7:0];
      idle_rate_r   <= 8'd0;
    end else if (cfg_write) begin
      case (paddr[2])
        ptre_pkg::REG_REPORT_MODE: report_mode_r <= pwdata[7:0];
        ptre_pkg::REG_IDLE_RATE:   idle_rate_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Absolute position scaling onto the tablet grid.
  ptre_scale #(
    .MAX_VAL (TABLET_MAX_X)
  ) u_scale_x (
    .pos    (in_ch.data.position_x),
    .scaled (scale_x)
  );

  ptre_scale #(
    .MAX_VAL (TABLET_MAX_Y)
  ) u_scale_y (
    .pos    (in_ch.data.position_y),
    .scaled (scale_y)
  );

  // The part of each axis a mouse report can carry.
  assign clamp_x     = clamp_byte(accum_x_r);
  assign clamp_y     = clamp_byte(accum_y_r);
  assign clamp_wheel = clamp_byte(accum_wheel_r);

  always_comb begin
    logic do_report;

    accum_x_nxt      = accum_x_r;
    accum_y_nxt      = accum_y_r;
    accum_wheel_nxt  = accum_wheel_r;
    scaled_x_nxt     = scaled_x_r;
    scaled_y_nxt     = scaled_y_r;
    held_buttons_nxt = held_buttons_r;
    fresh_data_nxt   = fresh_data_r;
    out_data_nxt     = '0;
    has_result       = 1'b1;
    do_report        = 1'b0;

    case (in_ch.data.func)
      ptre_pkg::FUNC_MOTION: begin
        accum_x_nxt      = sat_add(accum_x_r, in_ch.data.delta_x);
        accum_y_nxt      = sat_add(accum_y_r, in_ch.data.delta_y);
        accum_wheel_nxt  = sat_add(accum_wheel_r, in_ch.data.delta_wheel);
        held_buttons_nxt = in_ch.data.button_bits;
        fresh_data_nxt   = 1'b1;
        has_result       = 1'b0;
      end
      ptre_pkg::FUNC_ABSOLUTE: begin
        scaled_x_nxt     = scale_x;
        scaled_y_nxt     = scale_y[ptre_pkg::SCALED_W-2:0];
        accum_wheel_nxt  = sat_add(accum_wheel_r, in_ch.data.delta_wheel);
        held_buttons_nxt = in_ch.data.button_bits;
        fresh_data_nxt   = 1'b1;
        has_result       = 1'b0;
      end
      ptre_pkg::FUNC_IN_TOKEN: begin
        if (in_ch.data.endpoint != ptre_pkg::REPORT_ENDPOINT) begin
          out_data_nxt.status = ptre_pkg::STATUS_STALL;
        end else if (!fresh_data_r && idle_rate_r == 8'd0) begin
          // Nothing new since the last answered poll and no idle reports.
          out_data_nxt.status = ptre_pkg::STATUS_NAK;
        end else begin
          fresh_data_nxt = 1'b0;
          do_report      = 1'b1;
        end
      end
      ptre_pkg::FUNC_GET_REPORT: begin
        do_report = 1'b1;
      end
      default: begin
        // OUT tokens and unknown operations stall.
        out_data_nxt.status = ptre_pkg::STATUS_STALL;
      end
    endcase

    if (do_report) begin
      out_data_nxt.status = ptre_pkg::STATUS_REPORT;
      if (report_mode_r == ptre_pkg::MODE_MOUSE) begin
        // The part that is sent is taken off the accumulators.
        accum_x_nxt                = accum_x_r - clamp_x;
        accum_y_nxt                = accum_y_r - clamp_y;
        out_data_nxt.report_byte0  = {5'd0, held_buttons_r};
        out_data_nxt.report_byte1  = clamp_x[7:0];
        out_data_nxt.report_byte2  = clamp_y[7:0];
        out_data_nxt.report_length = ptre_pkg::MOUSE_LEN_SHORT;
        if (in_ch.data.room >= ptre_pkg::MOUSE_ROOM_MIN) begin
          accum_wheel_nxt            = accum_wheel_r - clamp_wheel;
          out_data_nxt.report_byte3  = clamp_wheel[7:0];
          out_data_nxt.report_length = ptre_pkg::MOUSE_LEN_FULL;
        end
      end else if (report_mode_r == ptre_pkg::MODE_TABLET) begin
        if (in_ch.data.room >= ptre_pkg::TABLET_ROOM_MIN) begin
          out_data_nxt.report_length = ptre_pkg::TABLET_LEN;
          out_data_nxt.report_byte0  = report_mode_r;
          out_data_nxt.report_byte1  = scaled_x_r[7:0];
          out_data_nxt.report_byte2  = 8'(scaled_x_r[ptre_pkg::SCALED_W-1:8]);
          out_data_nxt.report_byte3  = scaled_y_r[7:0];
          out_data_nxt.report_byte4  = 8'(scaled_y_r[ptre_pkg::SCALED_W-2:8]);
          // Right button maps to 0x40 and middle to 0x20.
          out_data_nxt.report_byte5  = {1'b0, held_buttons_r[1], held_buttons_r[2], 5'd0};
          // Left or middle button down means the pen touches.
          out_data_nxt.report_byte6  = (held_buttons_r[0] || held_buttons_r[2]) ?
                                       8'd0 : ptre_pkg::PRESSURE_LIFTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_x_r      <= '0;
      accum_y_r      <= '0;
      accum_wheel_r  <= '0;
      scaled_x_r     <= '0;
      scaled_y_r     <= '0;
      held_buttons_r <= '0;
      fresh_data_r   <= 1'b1;
    end else if (in_accept) begin
      accum_x_r      <= accum_x_nxt;
      accum_y_r      <= accum_y_nxt;
      accum_wheel_r  <= accum_wheel_nxt;
      scaled_x_r     <= scaled_x_nxt;
      scaled_y_r     <= scaled_y_nxt;
      held_buttons_r <= held_buttons_nxt;
      fresh_data_r   <= fresh_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && has_result) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: verif/tb_pointer_tablet_report_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_tablet_report_engine: self-checking bench of the report engine
// Drives motion events, absolute positions and bus tokens into the engine,
// predicts every mouse, tablet, NAK and stall answer with a behavioral copy
// of the engine, and compares each result transaction against it. Both
// channel sides idle at random, and the mode registers are reprogrammed
// between phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb_pointer_tablet_report_engine;

  // Tablet grid and host scale, matching the default parameters of the DUT.
  localparam int TAB_MAX_X = 5040;
  localparam int TAB_MAX_Y = 3780;
  localparam int HOST_FULL = 32'h7FFF;

  // Accumulator saturation bounds for a 16-bit signed accumulator.
  localparam int ACC_HI = 32767;
  localparam int ACC_LO = -32768;

  // Cycles allowed after the last result before the engine counts as idle.
  // The only register between an input and its result is the output register.
  localparam int SETTLE_CYCLES = 4;

  // Hard stop for a hung run; the slowest legal run is far below this.
  localparam int LIMIT_CYCLES = 400000;

  // Percentage of cycles in which a side idles while idling is enabled.
  localparam int IDLE_PCT = 33;

  logic clk;
  logic rst_n;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ptre_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ptre_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ptre_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  ptre_in_if  in_ch ();
  ptre_out_if out_ch ();

  pointer_tablet_report_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the engine. It is advanced at the clock edge where an
  // input transaction is accepted, so the expected answer of each token is
  // known before the engine can present it.
  // --------------------------------------------------------------------------
  logic [7:0]         mode_reg;
  logic [7:0]         idle_reg;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_wheel;
  logic [12:0]        tab_x;
  logic [11:0]        tab_y;
  logic [2:0]         buttons;
  bit                 fresh;

  // Answers the engine still owes, oldest first.
  ptre_pkg::out_item_t pending_reports[$];

  int  mismatches;
  int  cycle_count;
  bit  calm;   // when set, neither side idles

  // --------------------------------------------------------------------------
  // Clock, time-out and back-pressure on the result side.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_pointer_tablet_report_engine NOT OK");
      $finish;
    end
  end

  // The result side drops ready at random on falling edges, so a stall can
  // land on any cycle of the engine's work.
  always @(negedge clk) begin
    out_ch.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Behavioral model of the engine.
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] sat_accum(logic signed [15:0] acc,
                                                   logic signed [15:0] delta);
    int sum;
    sum = int'(acc) + int'(delta);
    if (sum > ACC_HI) sum = ACC_HI;
    if (sum < ACC_LO) sum = ACC_LO;
    return 16'(sum);
  endfunction

  function automatic int clamp_byte(int v);
    if (v < -128) return -128;
    if (v > 127) return 127;
    return v;
  endfunction

  // Builds the report of the current mode. In mouse mode the part of each
  // accumulator that fits into a signed byte is sent and taken off; the
  // wheel only travels when the host offers at least four bytes.
  function automatic void build_report(logic [6:0] room, inout ptre_pkg::out_item_t rep);
    int         dx;
    int         dy;
    int         dz;
    logic [7:0] tb;
    if (mode_reg == ptre_pkg::MODE_MOUSE) begin
      dx = clamp_byte(int'(acc_x));
      dy = clamp_byte(int'(acc_y));
      acc_x = acc_x - 16'(dx);
      acc_y = acc_y - 16'(dy);
      rep.report_byte0  = {5'b0, buttons};
      rep.report_byte1  = 8'(dx);
      rep.report_byte2  = 8'(dy);
      rep.report_length = ptre_pkg::MOUSE_LEN_SHORT;
      if (room >= ptre_pkg::MOUSE_ROOM_MIN) begin
        dz = clamp_byte(int'(acc_wheel));
        acc_wheel = acc_wheel - 16'(dz);
        rep.report_byte3  = 8'(dz);
        rep.report_length = ptre_pkg::MOUSE_LEN_FULL;
      end
    end else if (mode_reg == ptre_pkg::MODE_TABLET) begin
      tb = 8'h00;
      if (buttons[0]) tb |= 8'h01;
      if (buttons[1]) tb |= 8'h40;
      if (buttons[2]) tb |= 8'h20;
      // Too little room gives an empty but successful report.
      if (room >= ptre_pkg::TABLET_ROOM_MIN) begin
        rep.report_length = ptre_pkg::TABLET_LEN;
        rep.report_byte0  = mode_reg;
        rep.report_byte1  = tab_x[7:0];
        rep.report_byte2  = {3'b0, tab_x[12:8]};
        rep.report_byte3  = tab_y[7:0];
        rep.report_byte4  = {4'b0, tab_y[11:8]};
        rep.report_byte5  = tb & 8'hF0;
        rep.report_byte6  = ((tb & 8'h3F) != 8'h00) ? 8'h00 : ptre_pkg::PRESSURE_LIFTED;
      end
    end
  endfunction

  // Advances the model by one input transaction. Returns 1 when the item
  // produces a result transaction, which is then placed in rep.
  function automatic bit predict_report(input ptre_pkg::in_item_t it,
                                        output ptre_pkg::out_item_t rep);
    rep = '0;
    if (it.func == ptre_pkg::FUNC_MOTION) begin
      acc_x     = sat_accum(acc_x, it.delta_x);
      acc_y     = sat_accum(acc_y, it.delta_y);
      acc_wheel = sat_accum(acc_wheel, it.delta_wheel);
      buttons   = it.button_bits;
      fresh     = 1'b1;
      return 1'b0;
    end
    if (it.func == ptre_pkg::FUNC_ABSOLUTE) begin
      tab_x     = 13'((int'(it.position_x) * TAB_MAX_X) / HOST_FULL);
      tab_y     = 12'((int'(it.position_y) * TAB_MAX_Y) / HOST_FULL);
      acc_wheel = sat_accum(acc_wheel, it.delta_wheel);
      buttons   = it.button_bits;
      fresh     = 1'b1;
      return 1'b0;
    end
    if (it.func == ptre_pkg::FUNC_IN_TOKEN && it.endpoint == ptre_pkg::REPORT_ENDPOINT) begin
      // An interrupt poll with nothing new is refused unless idle reporting
      // is on. An answered poll consumes the fresh flag, even when empty.
      if (!fresh && idle_reg == 8'd0) begin
        rep.status = ptre_pkg::STATUS_NAK;
        return 1'b1;
      end
      fresh = 1'b0;
      build_report(it.room, rep);
      return 1'b1;
    end
    if (it.func == ptre_pkg::FUNC_GET_REPORT) begin
      build_report(it.room, rep);
      return 1'b1;
    end
    // Foreign endpoints, OUT tokens and unknown operations stall.
    rep.status = ptre_pkg::STATUS_STALL;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every result transaction is matched with the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, ptre_pkg::out_item_t want,
                                 ptre_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns %s: expected st=%0d len=%0d %h %h %h %h %h %h %h", $time, what,
               want.status, want.report_length, want.report_byte0, want.report_byte1,
               want.report_byte2, want.report_byte3, want.report_byte4,
               want.report_byte5, want.report_byte6);
      $display("%0t ns %s:   actual st=%0d len=%0d %h %h %h %h %h %h %h", $time, what,
               got.status, got.report_length, got.report_byte0, got.report_byte1,
               got.report_byte2, got.report_byte3, got.report_byte4,
               got.report_byte5, got.report_byte6);
    end
  endtask

  always @(posedge clk) begin
    ptre_pkg::out_item_t got;
    ptre_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.report_length !== want.report_length ||
            got.report_byte0 !== want.report_byte0 ||
            got.report_byte1 !== want.report_byte1 ||
            got.report_byte2 !== want.report_byte2 ||
            got.report_byte3 !== want.report_byte3 ||
            got.report_byte4 !== want.report_byte4 ||
            got.report_byte5 !== want.report_byte5 ||
            got.report_byte6 !== want.report_byte6) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. send_event holds valid until the engine takes the
  // transaction; valid stays high into the next call, which either drives
  // the next item or drops valid while it idles.
  // --------------------------------------------------------------------------
  task automatic send_event(ptre_pkg::in_item_t it);
    ptre_pkg::out_item_t rep;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_report(it, rep)) pending_reports.push_back(rep);
  endtask

  // Stops sending and waits until every owed answer has arrived, plus a
  // short settling time for events that produce no answer.
  task automatic wait_quiescent();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register over the configuration port, then reads it back.
  task automatic set_register(logic idx, logic [7:0] value);
    logic [ptre_pkg::CFG_ADDR_W-1:0] addr;
    addr = ptre_pkg::CFG_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {24'b0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ptre_pkg::REG_REPORT_MODE) mode_reg = value;
    else idle_reg = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns register %0d read back: expected %h actual %h", $time, idx,
                 value, prdata[7:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(logic [7:0] mode, logic [7:0] idle);
    wait_quiescent();
    set_register(ptre_pkg::REG_REPORT_MODE, mode);
    set_register(ptre_pkg::REG_IDLE_RATE, idle);
  endtask

  function automatic ptre_pkg::in_item_t make_item(logic [2:0] func, int dx, int dy, int dw,
                                                   int px, int py, int btn, int ep,
                                                   int room);
    ptre_pkg::in_item_t it;
    it.func        = func;
    it.delta_x     = 16'(dx);
    it.delta_y     = 16'(dy);
    it.delta_wheel = 16'(dw);
    it.position_x  = 15'(px);
    it.position_y  = 15'(py);
    it.button_bits = 3'(btn);
    it.endpoint    = 4'(ep);
    it.room        = 7'(room);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers.
  // --------------------------------------------------------------------------
  // Mostly small motion, which lets the mouse reports drain the accumulators,
  // mixed with full-range values and the saturation extremes.
  function automatic int rand_delta();
    case ($urandom_range(0, 9))
      0:       return ACC_LO;
      1:       return ACC_HI;
      2, 3:    return int'($signed(16'($urandom())));
      default: return int'($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  // Room values cluster around the mouse and tablet thresholds.
  function automatic int rand_room();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 127);
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(4, 6);
      3:       return 7;
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // Mostly well-formed traffic (events followed by polls on endpoint 1),
  // with some stalling tokens and unknown operations mixed in. Every field
  // carries random content, even where the operation ignores it.
  function automatic ptre_pkg::in_item_t rand_event();
    ptre_pkg::in_item_t it;
    int                 pick;
    int                 ep;
    it = make_item(ptre_pkg::FUNC_MOTION, rand_delta(), rand_delta(), rand_delta(),
                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 7), $urandom_range(0, 15), rand_room());
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.func = ptre_pkg::FUNC_MOTION;
    end else if (pick < 45) begin
      it.func = ptre_pkg::FUNC_ABSOLUTE;
    end else if (pick < 72) begin
      it.func     = ptre_pkg::FUNC_IN_TOKEN;
      it.endpoint = ptre_pkg::REPORT_ENDPOINT;
    end else if (pick < 87) begin
      it.func = ptre_pkg::FUNC_GET_REPORT;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          // IN token on any endpoint but the served one.
          ep = $urandom_range(0, 14);
          if (ep >= 1) ep++;
          it.func     = ptre_pkg::FUNC_IN_TOKEN;
          it.endpoint = 4'(ep);
        end
        1:       it.func = ptre_pkg::FUNC_OUT_TOKEN;
        default: it.func = 3'($urandom_range(5, 7));
      endcase
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------
  // Right after reset the data counts as fresh, so the first poll answers
  // with an all-zero report and the second one is refused.
  task automatic test_poll_after_reset();
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 4));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 4));
  endtask

  // Drives the accumulators into both saturation limits and drains them
  // with reports of every room class, so the wheel is held back when the
  // host offers fewer than four bytes.
  task automatic test_mouse_saturation();
    send_event(make_item(ptre_pkg::FUNC_MOTION, ACC_HI, ACC_HI, ACC_HI, 0, 0, 7, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_MOTION, ACC_HI, ACC_HI, ACC_HI, 32767, 32767, 7,
                         15, 64));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 64));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 3));
    send_event(make_item(ptre_pkg::FUNC_MOTION, ACC_LO, ACC_LO, ACC_LO, 0, 0, 5, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_MOTION, ACC_LO, ACC_LO, ACC_LO, 0, 0, 2, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 4));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 2));
    send_event(make_item(ptre_pkg::FUNC_MOTION, -1, 1, -128, 0, 0, 1, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 127));
  endtask

  // Foreign endpoints, OUT tokens and the unassigned operation codes.
  task automatic test_stall_tokens();
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0, 0, 64));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0, 15, 64));
    send_event(make_item(ptre_pkg::FUNC_OUT_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(3'd5, 0, 0, 0, 0, 0, 0, ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(3'd6, 0, 0, 0, 0, 0, 0, ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(3'd7, -1, -1, -1, 32767, 32767, 7, 15, 127));
  endtask

  // Tablet reports at full scale and at the origin, with all buttons down,
  // with the right button alone and with the middle button alone, and with too
  // little room for the seven-byte report.
  task automatic test_tablet_reports();
    configure(ptre_pkg::MODE_TABLET, 8'd0);
    send_event(make_item(ptre_pkg::FUNC_ABSOLUTE, 0, 0, 5, 32767, 32767, 7, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 6));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 7));
    send_event(make_item(ptre_pkg::FUNC_ABSOLUTE, 0, 0, 0, 0, 0, 2, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(ptre_pkg::FUNC_ABSOLUTE, 0, 0, -5, 16384, 100, 4, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 127));
  endtask

  // Report modes other than mouse and tablet give empty reports, and a
  // nonzero idle rate makes every poll answer.
  task automatic test_other_modes();
    configure(8'd0, 8'd0);
    send_event(make_item(ptre_pkg::FUNC_MOTION, 3, 3, 3, 0, 0, 1, 0, 0));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(ptre_pkg::FUNC_GET_REPORT, 0, 0, 0, 0, 0, 0, 0, 64));
    configure(8'hFF, 8'hFF);
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 64));
    configure(ptre_pkg::MODE_MOUSE, 8'hFF);
    send_event(make_item(ptre_pkg::FUNC_IN_TOKEN, 0, 0, 0, 0, 0, 0,
                         ptre_pkg::REPORT_ENDPOINT, 4));
  endtask

  // One phase of random traffic under one register setting. Halfway through
  // the sender holds off until every answer is in, so the engine also sees
  // traffic restart from an empty pipeline.
  task automatic test_random_traffic(int count, logic [7:0] mode, logic [7:0] idle,
                                     bit no_idling);
    configure(mode, idle);
    calm = no_idling;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_quiescent();
      send_event(rand_event());
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    cycle_count  = 0;
    calm         = 1'b0;

    // Model state after reset.
    mode_reg  = ptre_pkg::REPORT_MODE_RESET[7:0];
    idle_reg  = 8'd0;
    acc_x     = '0;
    acc_y     = '0;
    acc_wheel = '0;
    tab_x     = '0;
    tab_y     = '0;
    buttons   = '0;
    fresh     = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_poll_after_reset();
    test_mouse_saturation();
    test_stall_tokens();
    test_tablet_reports();
    test_other_modes();

    test_random_traffic(220, ptre_pkg::MODE_MOUSE, 8'd0, 1'b0);
    test_random_traffic(160, ptre_pkg::MODE_MOUSE, 8'hFF, 1'b0);
    test_random_traffic(200, ptre_pkg::MODE_TABLET, 8'd0, 1'b0);
    test_random_traffic(200, ptre_pkg::MODE_MOUSE, 8'd1, 1'b1);
    test_random_traffic(160, ptre_pkg::MODE_TABLET, 8'd37, 1'b0);
    test_random_traffic(60, 8'd0, 8'd0, 1'b0);
    test_random_traffic(60, 8'hFF, 8'hFF, 1'b0);
    test_random_traffic(60, 8'($urandom_range(3, 254)), 8'($urandom()), 1'b0);
    test_random_traffic(130, ptre_pkg::MODE_MOUSE, 8'd0, 1'b0);

    wait_quiescent();
    if (mismatches == 0) begin
      $display("tb_pointer_tablet_report_engine OK");
    end else begin
      $display("tb_pointer_tablet_report_engine NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ptre_pkg.sv
hw/rtl/ptre_if.sv
hw/rtl/ptre_scale.sv
hw/rtl/pointer_tablet_report_engine.sv
verif/tb_pointer_tablet_report_engine.sv
